FILE: src/htd_pkg.sv
package htd_pkg;

  // Node table geometry
  localparam int NodeSlots = 256;
  localparam int NodeAw    = $clog2(NodeSlots);

  // Field widths
  localparam int EntryW  = 9;
  localparam int SymW    = 8;
  localparam int CountW  = 32;
  localparam int ByteW   = 8;
  localparam int IdxW    = 8;
  localparam int ActW    = 2;
  localparam int RegIdxW = 1;
  localparam int CfgW    = 32;
  localparam int BitCntW = $clog2(ByteW);

  typedef logic signed [EntryW-1:0] entry_t;
  typedef logic [2*EntryW-1:0]      node_t;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_START  = 2'd1,
    ACT_DECODE = 2'd2
  } action_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_ROOT_NODE    = 1'b0,
    REG_SYMBOL_COUNT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

endpackage

FILE: src/htd_if.sv
interface htd_item_if;
  import htd_pkg::*;

  logic                valid;
  logic                ready;
  logic [ActW-1:0]     action;
  logic [IdxW-1:0]     node_index;
  entry_t              left_entry;
  entry_t              right_entry;
  logic [ByteW-1:0]    data_byte;

  modport source (output valid, action, node_index, left_entry, right_entry, data_byte,
                  input ready);
  modport sink   (input valid, action, node_index, left_entry, right_entry, data_byte,
                  output ready);
endinterface

interface htd_result_if;
  import htd_pkg::*;

  logic            valid;
  logic            ready;
  logic [SymW-1:0] symbol;
  logic            last;
  logic            stream_done;

  modport source (output valid, symbol, last, stream_done, input ready);
  modport sink   (input valid, symbol, last, stream_done, output ready);
endinterface

interface htd_cfg_if;
  import htd_pkg::*;

  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/huffman_tree_decoder.sv
// Channel   Dir  Word carried
// item_i    in   action, node_index, left_entry, right_entry, data_byte
// result_o  out  symbol, last, stream_done (one word per decoded symbol)
// cfg_i     in   index, data (0 root_node, 1 symbol_count)
//
// Load and start words are taken while idle. A data byte is accepted,
// then walked one compressed bit per cycle unless the result side stalls,
// because each bit needs one node table read and the next address comes
// from that read. A new byte is not taken until the last one is done.
// Reset clears the walk state, the decoded count and both registers; the
// node table is not cleared and must be loaded before use.
module huffman_tree_decoder (
  input logic          clk_i,
  input logic          rst_ni,
  htd_item_if.sink     item_i,
  htd_result_if.source result_o,
  htd_cfg_if.sink      cfg_i
);
  import htd_pkg::*;

  // Control state
  state_e              state_q, state_d;
  logic [NodeAw-1:0]   cur_q, cur_d;
  logic                mid_q, mid_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                pend_valid_q, pend_valid_d;
  logic                out_valid_q, out_valid_d;

  // Configuration registers
  entry_t              root_q;
  logic [CountW-1:0]   symcnt_q;

  // Payload
  logic [ByteW-1:0]    bits_q, bits_d;
  logic [BitCntW-1:0]  bitcnt_q, bitcnt_d;
  logic [SymW-1:0]     pend_sym_q, pend_sym_d;
  logic                pend_done_q, pend_done_d;
  logic [SymW-1:0]     out_sym_q, out_sym_d;
  logic                out_last_q, out_last_d;
  logic                out_done_q, out_done_d;

  // Node table: left entry in the upper half, right entry in the lower half.
  node_t               node_mem [NodeSlots];
  node_t               rd_q;
  logic [NodeAw-1:0]   rd_addr;

  logic                item_acc;
  action_e             act;
  logic                load_ok;
  logic                start_walk;
  entry_t              child;
  logic                is_leaf;
  logic                out_free;
  logic [CountW-1:0]   count_inc;
  logic                hit;
  logic                last_bit;
  logic                walk_stall;
  logic [NodeAw-1:0]   root_addr;

  assign item_acc   = item_i.valid && item_i.ready;
  assign act        = action_e'(item_i.action);
  assign load_ok    = int'(item_i.node_index) < NodeSlots;
  assign root_addr  = root_q[NodeAw-1:0];

  // A data byte is only walked when the root is an internal node and the
  // stream still owes symbols; otherwise it is dropped without effect.
  assign start_walk = item_acc && (act == ACT_DECODE) && !root_q[EntryW-1] &&
                      (count_q < symcnt_q);

  // A set bit follows the left child, a clear bit the right child. A
  // negative child is a leaf whose symbol is the entry plus 256, which is
  // simply its low eight bits.
  assign child      = bits_q[ByteW-1] ? entry_t'(rd_q[2*EntryW-1:EntryW])
                                      : entry_t'(rd_q[EntryW-1:0]);
  assign is_leaf    = child[EntryW-1];
  assign out_free   = !out_valid_q || result_o.ready;
  assign count_inc  = count_q + CountW'(1);
  assign hit        = (count_inc == symcnt_q);
  assign last_bit   = (bitcnt_q == BitCntW'(ByteW - 1));

  // A new leaf needs the pending symbol moved to the output register, so
  // the walk waits while that register is still held by the sink.
  assign walk_stall = (state_q == ST_WALK) && is_leaf && pend_valid_q && !out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_walk) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!walk_stall && ((is_leaf && hit) || last_bit)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs. The last symbol of a byte is only known once the
  // byte is finished, so each symbol waits in the pending register until
  // either a later symbol or the end of the byte decides its last flag.
  always_comb begin
    cur_d        = cur_q;
    mid_d        = mid_q;
    count_d      = count_q;
    bits_d       = bits_q;
    bitcnt_d     = bitcnt_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_done_d  = pend_done_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;

    unique case (state_q)
      ST_IDLE: begin
        if (item_acc) begin
          case (act)
            ACT_START: begin
              count_d = '0;
              mid_d   = 1'b0;
              cur_d   = '0;
            end
            ACT_DECODE: begin
              bits_d   = item_i.data_byte;
              bitcnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (!walk_stall) begin
          bits_d   = bits_q << 1;
          bitcnt_d = bitcnt_q + BitCntW'(1);
          if (is_leaf) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_sym_d   = pend_sym_q;
              out_last_d  = 1'b0;
              out_done_d  = pend_done_q;
            end
            pend_valid_d = 1'b1;
            pend_sym_d   = child[SymW-1:0];
            pend_done_d  = hit;
            count_d      = count_inc;
            mid_d        = 1'b0;
            cur_d        = '0;
          end else begin
            cur_d = child[NodeAw-1:0];
            mid_d = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = pend_sym_q;
          out_last_d   = 1'b1;
          out_done_d   = pend_done_q;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // The table is read every cycle at the node the walk will stand on next,
  // so the data is ready when the following bit is examined. While the walk
  // stalls the same address is read again.
  assign rd_addr = mid_d ? cur_d : root_addr;

  assign item_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign result_o.valid     = out_valid_q;
  assign result_o.symbol    = out_sym_q;
  assign result_o.last      = out_last_q;
  assign result_o.stream_done = out_done_q;

  always_ff @(posedge clk_i) begin
    if (item_acc && (act == ACT_LOAD) && load_ok) begin
      node_mem[item_i.node_index[NodeAw-1:0]] <= {item_i.left_entry, item_i.right_entry};
    end
    rd_q <= node_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      mid_q        <= 1'b0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      mid_q        <= mid_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q   <= '0;
      symcnt_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (reg_e'(cfg_i.index))
        REG_ROOT_NODE:    root_q   <= entry_t'(cfg_i.data[EntryW-1:0]);
        REG_SYMBOL_COUNT: symcnt_q <= cfg_i.data[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q      <= bits_d;
    bitcnt_q    <= bitcnt_d;
    pend_sym_q  <= pend_sym_d;
    pend_done_q <= pend_done_d;
    out_sym_q   <= out_sym_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
  end

  // A symbol never waits in the pending register once the byte is finished.
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending symbol left over after a byte");

  // Every new output word comes from the pending register.
  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_valid_q))
    else $error("output word without a pending symbol");

  // The symbol that completes the stream closes its byte.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("stream end not marked as last word of its byte");

  // Flushing with nothing pending returns to idle at once.
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH) && !pend_valid_q) |=> (state_q == ST_IDLE))
    else $error("flush stuck with no pending symbol");

endmodule
